// ===== hdl/dtpc_pkg.sv =====
// shared types, codes and color helpers for the display transfer pixel converter
// no dependencies; imported by every module of the block
package dtpc_pkg;

	// register field width and default dimension limit
	localparam int DIM_W = 11;
	localparam int CFG_IDX_W = 4;
	localparam int MAX_DIMENSION_DEF = 1024;
	localparam int DOFF_W = 22;
	localparam int SOFF_W = 24;
	localparam int PROD_W = 2 * DIM_W;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SRC_FMT = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DST_FMT = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FLIP = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_W = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_H = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DST_W = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DST_H = 4'd7;

	// source formats
	localparam logic [1:0] SF_RGBA8 = 2'd0;
	localparam logic [1:0] SF_RGB565 = 2'd1;
	localparam logic [1:0] SF_RGBA5551 = 2'd2;
	localparam logic [1:0] SF_RGBA4 = 2'd3;

	// destination formats
	localparam logic [2:0] DF_RGBA8 = 3'd0;
	localparam logic [2:0] DF_RGB8 = 3'd1;
	localparam logic [2:0] DF_RGB565 = 3'd2;
	localparam logic [2:0] DF_RGBA5551 = 3'd3;
	localparam logic [2:0] DF_RGBA4 = 3'd4;

	// scale modes
	localparam logic [1:0] SCALE_NONE = 2'd0;
	localparam logic [1:0] SCALE_X = 2'd1;
	localparam logic [1:0] SCALE_XY = 2'd2;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic mul;
		logic finish;
	} dtpc_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic cfg_write;
	} dtpc_status_t;

	function automatic logic [7:0] rep5(input logic [4:0] v);
		rep5 = {v, v[4:2]};
	endfunction

	function automatic logic [7:0] rep6(input logic [5:0] v);
		rep6 = {v, v[5:4]};
	endfunction

	function automatic logic [7:0] rep4(input logic [3:0] v);
		rep4 = {v, v};
	endfunction

	// expand to 8-bit channels, then pack into the destination format
	function automatic logic [31:0] convert(input logic [1:0] sfmt, input logic [2:0] dfmt,
		input logic [31:0] w);
		logic [7:0] r, g, b, a;
		logic [31:0] px;
		unique case (sfmt)
			SF_RGBA8: begin
				r = w[31:24]; g = w[23:16]; b = w[15:8]; a = w[7:0];
			end
			SF_RGB565: begin
				r = rep5(w[15:11]); g = rep6(w[10:5]); b = rep5(w[4:0]); a = 8'hFF;
			end
			SF_RGBA5551: begin
				r = rep5(w[15:11]); g = rep5(w[10:6]); b = rep5(w[5:1]);
				a = w[0] ? 8'hFF : 8'h00;
			end
			default: begin
				r = rep4(w[15:12]); g = rep4(w[11:8]); b = rep4(w[7:4]); a = rep4(w[3:0]);
			end
		endcase
		unique case (dfmt)
			DF_RGBA8: px = {r, g, b, a};
			DF_RGB8: px = {8'h00, r, g, b};
			DF_RGB565: px = {16'h0000, r[7:3], g[7:2], b[7:3]};
			DF_RGBA5551: px = {16'h0000, r[7:3], g[7:3], b[7:3], a[7]};
			default: px = {16'h0000, r[7:4], g[7:4], b[7:4], a[7:4]};
		endcase
		convert = px;
	endfunction

endpackage

// ===== hdl/display_transfer_pixel_converter_core.sv =====
// top level of the display transfer pixel converter
// depends on dtpc_pkg, dtpc_ctrl and dtpc_datapath
//
// channel   direction  handshake            payload
// input     in         in_valid / in_stall  source_pixel
// output    out        out_valid / out_stall dest_pixel, dest_bytes, dest_offset,
//                                            source_offset, last_pixel, status
// config    in         cfg_we               cfg_index, cfg_data
//
// each pixel is captured and converted, then row multiplied, then summed into
// the output beat register; the next pixel waits until the final step is done.
// reset (asynchronous) clears the config registers to defaults and the counters.
// a stalled output holds the beat and the item waiting in the final step; the
// next pixel is still taken while a finished beat waits.
module display_transfer_pixel_converter_core
	import dtpc_pkg::*;
#(
	parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [31:0]          source_pixel,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [31:0]          dest_pixel,
	output logic [2:0]           dest_bytes,
	output logic [DOFF_W-1:0]    dest_offset,
	output logic [SOFF_W-1:0]    source_offset,
	output logic                 last_pixel,
	output logic                 status
);

	dtpc_cmd_t    cmd;
	dtpc_status_t dp_status;

	dtpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status_i (dp_status),
		.cmd      (cmd)
	);

	dtpc_datapath #(
		.MAX_DIMENSION(MAX_DIMENSION)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.source_pixel (source_pixel),
		.cmd          (cmd),
		.status_o     (dp_status),
		.dest_pixel   (dest_pixel),
		.dest_bytes   (dest_bytes),
		.dest_offset  (dest_offset),
		.source_offset(source_offset),
		.last_pixel   (last_pixel),
		.status       (status)
	);

endmodule

// ===== hdl/dtpc_ctrl.sv =====
// sequencing controller: accept, multiply, finish, output beat register valid
// depends on dtpc_pkg
module dtpc_ctrl
	import dtpc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	output logic         out_valid,
	input  logic         out_stall,
	input  dtpc_status_t status_i,
	output dtpc_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL = 2'd1;
	localparam logic [1:0] ST_FIN = 2'd2;

	logic [1:0] state_q;
	logic       out_valid_q;
	logic       out_free;

	// command decode
	always_comb begin
		out_free = !out_valid_q || !out_stall;
		in_stall = (state_q != ST_IDLE) || status_i.cfg_write;
		cmd.load = in_valid && !in_stall;
		cmd.mul = (state_q == ST_MUL);
		cmd.finish = (state_q == ST_FIN) && out_free;
	end

	assign out_valid = out_valid_q;

	// state sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (cmd.load) state_q <= ST_MUL;
				ST_MUL: state_q <= ST_FIN;
				ST_FIN: if (cmd.finish) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== hdl/dtpc_datapath.sv =====
// config registers, raster counters, color conversion and offset arithmetic
// depends on dtpc_pkg; driven by dtpc_ctrl commands
module dtpc_datapath
	import dtpc_pkg::*;
#(
	parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  logic [31:0]          source_pixel,
	input  dtpc_cmd_t            cmd,
	output dtpc_status_t         status_o,
	output logic [31:0]          dest_pixel,
	output logic [2:0]           dest_bytes,
	output logic [DOFF_W-1:0]    dest_offset,
	output logic [SOFF_W-1:0]    source_offset,
	output logic                 last_pixel,
	output logic                 status
);

	localparam int CNT_RAW = $clog2(MAX_DIMENSION);
	localparam int CNT_W = (CNT_RAW > DIM_W) ? DIM_W : CNT_RAW;
	localparam logic [DIM_W+1:0] MAX_C = (DIM_W + 2)'(MAX_DIMENSION);

	function automatic logic [DIM_W-1:0] clamp(input logic [DIM_W-1:0] v);
		clamp = ({2'b00, v} > MAX_C) ? MAX_C[DIM_W-1:0] : v;
	endfunction

	// configuration registers
	logic [1:0]       src_fmt_q, scale_q;
	logic [2:0]       dst_fmt_q;
	logic             flip_q;
	logic [DIM_W-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
	logic [CNT_W-1:0] col_q, row_q;
	logic             cfg_hit;

	// decoded configuration
	logic [DIM_W-1:0] sw, sh, dw, dh, scaled_w, scaled_h;
	logic             hs, vs, sb_sh, bad;
	logic [2:0]       dbytes;

	// current position and next position
	logic [DIM_W-1:0] x, y, x_inc, y_inc, srow;

	// stage 1: accepted item
	logic [31:0]      px_s1;
	logic [2:0]       dbytes_s1;
	logic [DIM_W-1:0] x_s1, y_s1, srow_s1, scaled_w_s1, sw_s1;
	logic [1:0]       xsh_s1, rsh_s1;
	logic             bad_s1, last_s1;

	// stage 2: products
	logic [PROD_W-1:0] pd_s2, ps_s2;

	// final sums
	logic [DOFF_W-1:0] lin, doff;
	logic [SOFF_W+1:0] soff_wide;

	assign cfg_hit = cfg_we && (cfg_index <= REG_DST_H);
	assign status_o.cfg_write = cfg_we;

	always_comb begin
		sw = clamp(src_w_q);
		sh = clamp(src_h_q);
		dw = clamp(dst_w_q);
		dh = clamp(dst_h_q);
		hs = (scale_q != SCALE_NONE);
		vs = (scale_q == SCALE_XY);
		scaled_w = hs ? (dw >> 1) : dw;
		scaled_h = vs ? (dh >> 1) : dh;
		// extra shift for a four-byte source pixel
		sb_sh = (src_fmt_q == SF_RGBA8);
		unique case (dst_fmt_q)
			DF_RGBA8: dbytes = 3'd4;
			DF_RGB8: dbytes = 3'd3;
			DF_RGB565, DF_RGBA5551, DF_RGBA4: dbytes = 3'd2;
			default: dbytes = 3'd4;
		endcase
		bad = (dh > sh) || (flip_q && (dh != sh)) || (scaled_w == '0) || (scaled_h == '0)
			|| (scale_q > SCALE_XY) || (dst_fmt_q > DF_RGBA4);
		x = DIM_W'(col_q);
		y = DIM_W'(row_q);
		if (x >= scaled_w || y >= scaled_h) begin
			x = '0;
			y = '0;
		end
		srow = flip_q ? (sh - 1'b1 - y) : y;
		x_inc = x + 1'b1;
		y_inc = y + 1'b1;
	end

	// configuration writes, each restarts the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_fmt_q <= SF_RGBA8;
			dst_fmt_q <= DF_RGBA8;
			scale_q <= SCALE_NONE;
			flip_q <= 1'b0;
			src_w_q <= DIM_W'(1);
			src_h_q <= DIM_W'(1);
			dst_w_q <= DIM_W'(2);
			dst_h_q <= DIM_W'(2);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SRC_FMT: src_fmt_q <= cfg_data[1:0];
				REG_DST_FMT: dst_fmt_q <= cfg_data[2:0];
				REG_SCALE: scale_q <= cfg_data[1:0];
				REG_FLIP: flip_q <= cfg_data[0];
				REG_SRC_W: src_w_q <= cfg_data;
				REG_SRC_H: src_h_q <= cfg_data;
				REG_DST_W: dst_w_q <= cfg_data;
				REG_DST_H: dst_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_hit) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.load && !bad) begin
			if (x_inc >= scaled_w) begin
				col_q <= '0;
				row_q <= (y_inc >= scaled_h) ? '0 : y_inc[CNT_W-1:0];
			end else begin
				col_q <= x_inc[CNT_W-1:0];
			end
		end
	end

	// capture the accepted pixel
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_s1 <= bad ? 32'h0 : convert(src_fmt_q, dst_fmt_q, source_pixel);
			dbytes_s1 <= dbytes;
			bad_s1 <= bad;
			x_s1 <= x;
			y_s1 <= y;
			srow_s1 <= srow;
			scaled_w_s1 <= scaled_w;
			sw_s1 <= sw;
			xsh_s1 <= {1'b0, sb_sh} + {1'b0, hs} + 2'd1;
			rsh_s1 <= {1'b0, sb_sh} + {1'b0, vs} + 2'd1;
			last_s1 <= !bad && (x == scaled_w - 1'b1) && (y == scaled_h - 1'b1);
		end
	end

	// row products
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			pd_s2 <= y_s1 * scaled_w_s1;
			ps_s2 <= srow_s1 * sw_s1;
		end
	end

	// byte offsets, wrapped to field width
	always_comb begin
		lin = pd_s2[DOFF_W-1:0] + DOFF_W'(x_s1);
		unique case (dbytes_s1)
			3'd3: doff = (lin << 1) + lin;
			3'd2: doff = lin << 1;
			default: doff = lin << 2;
		endcase
		soff_wide = ((SOFF_W + 2)'(ps_s2) << rsh_s1)
			+ ((SOFF_W + 2)'(x_s1) << xsh_s1);
	end

	// output beat register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			dest_pixel <= px_s1;
			dest_bytes <= dbytes_s1;
			dest_offset <= bad_s1 ? '0 : doff;
			source_offset <= bad_s1 ? '0 : soff_wide[SOFF_W-1:0];
			last_pixel <= last_s1;
			status <= bad_s1;
		end
	end

endmodule
